>>> src/sm3_pkg.sv
// sm3 hash package: item types, constants and round functions
package sm3_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_comp_stat;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h7380166f;
            3'd1: v = 32'h4914b2b9;
            3'd2: v = 32'h172442d7;
            3'd3: v = 32'hda8a0600;
            3'd4: v = 32'ha96f30bc;
            3'd5: v = 32'h163138aa;
            3'd6: v = 32'he38dee4d;
            default: v = 32'hb0fb0e4e;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

>>> src/sm3_front.sv
// sm3 front end: input word queue with byte count clamping
module sm3_front #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sm3_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output sm3_pkg::t_in_item o_head,
    input  logic              i_take
);
    import sm3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_in_item        r_slot [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    t_in_item        clamped;
    logic            wr, rd;

    always_comb begin
        clamped = i_item;
        if (i_item.byte_count[2] && (i_item.byte_count[1:0] != 2'd0)) begin
            clamped.byte_count = 3'd4;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wp] <= clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/sm3_comp.sv
// sm3 compression unit: message expansion window and one round per cycle
module sm3_comp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0][31:0]   i_block,
    input  logic [7:0][31:0]    i_chain,
    output sm3_pkg::t_comp_stat o_stat,
    output logic [7:0][31:0]    o_vars
);
    import sm3_pkg::*;

    logic [31:0] r_w [16];
    logic [7:0][31:0] r_v;
    logic [5:0]  r_j;
    logic        r_busy, r_done;

    logic [31:0] w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic        early;

    assign early = (r_j[5:4] == 2'd0);
    assign w_new = perm1(r_w[0] ^ r_w[7] ^ rotl32(r_w[13], 5'd15))
                 ^ rotl32(r_w[3], 5'd7) ^ r_w[10];
    assign tj    = rotl32(early ? T_LOW : T_HIGH, r_j[4:0]);
    assign a12   = rotl32(r_v[0], 5'd12);
    assign ss1   = rotl32(a12 + r_v[4] + tj, 5'd7);
    assign ss2   = ss1 ^ a12;

    always_comb begin
        if (early) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
    end

    assign tt1 = ff + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
    assign tt2 = gg + r_v[7] + ss1 + r_w[0];

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_vars      = r_v;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 16; k++) begin
                r_w[k] <= i_block[k];
            end
            r_v <= i_chain;
        end else if (r_busy) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k+1];
            end
            r_w[15] <= w_new;
            r_v[0] <= tt1;
            r_v[1] <= r_v[0];
            r_v[2] <= rotl32(r_v[1], 5'd9);
            r_v[3] <= r_v[2];
            r_v[4] <= perm0(tt2);
            r_v[5] <= r_v[4];
            r_v[6] <= rotl32(r_v[5], 5'd19);
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_j    <= '0;
        end else begin
            r_done <= r_busy && (r_j == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_j    <= '0;
            end else if (r_busy) begin
                r_j <= r_j + 1'b1;
                if (r_j == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while busy");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_j == 6'd63)) |=> (!r_busy && r_done)) else $error("bad end");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");

endmodule

>>> src/sm3_back.sv
// sm3 back end: byte packing, padding, block sequencing and digest output
module sm3_back #(
    parameter int LENGTH_COUNTER_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sm3_pkg::t_in_item  i_head,
    output logic               o_take,
    output logic               o_empty,
    output sm3_pkg::t_out_item o_item,
    input  logic               i_pop
);
    import sm3_pkg::*;

    localparam int LW = LENGTH_COUNTER_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       r_state;
    logic [7:0]       r_buf [64];
    logic [7:0]       r_ov [3];
    logic [1:0]       r_ov_cnt;
    logic [5:0]       r_fill;
    logic [LW-1:0]    r_len;
    logic             r_pad_pend, r_pstage, r_final;
    logic [7:0][31:0] r_chain;
    logic [2:0]       r_oi;

    logic [15:0][31:0] blk;
    logic [7:0][31:0]  vars;
    t_comp_stat        cstat;
    logic              start;
    logic [6:0]        pos [4];
    logic [6:0]        sum;
    logic [63:0]       len64;
    logic              len_now;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            blk[k] = {r_buf[4*k], r_buf[4*k+1], r_buf[4*k+2], r_buf[4*k+3]};
        end
        for (int i = 0; i < 4; i++) begin
            pos[i] = {1'b0, r_fill} + 7'(i);
        end
    end

    assign sum     = {1'b0, r_fill} + 7'(i_head.byte_count);
    assign len64   = 64'(r_len);
    assign len_now = r_pstage || (r_fill < LEN_POS);
    assign start   = (r_state == S_LOAD);
    assign o_take  = (r_state == S_IDLE);
    assign o_empty = (r_state != S_OUT);

    assign o_item.digest_word = r_chain[r_oi];
    assign o_item.word_index  = r_oi;
    assign o_item.last_word   = (r_oi == 3'd7);

    sm3_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_block (blk),
        .i_chain (r_chain),
        .o_stat  (cstat),
        .o_vars  (vars)
    );

    // buffer bytes, move overflow bytes to the block start on load, and write padding
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < i_head.byte_count) begin
                            if (!pos[i][6]) begin
                                r_buf[pos[i][5:0]] <= i_head.msg_word[31-8*i -: 8];
                            end else begin
                                r_ov[pos[i][1:0]] <= i_head.msg_word[31-8*i -: 8];
                            end
                        end
                    end
                end
            end
            S_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_ov_cnt) begin
                        r_buf[i] <= r_ov[i];
                    end
                end
            end
            S_PAD: begin
                for (int j = 0; j < 64; j++) begin
                    if (!r_pstage && (6'(j) == r_fill)) begin
                        r_buf[j] <= PAD_BYTE;
                    end else if ((j >= 56) && len_now) begin
                        r_buf[j] <= len64[63-8*(j-56) -: 8];
                    end else if (r_pstage || (6'(j) > r_fill)) begin
                        r_buf[j] <= 8'h00;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_len      <= '0;
            r_ov_cnt   <= '0;
            r_pad_pend <= 1'b0;
            r_pstage   <= 1'b0;
            r_final    <= 1'b0;
            r_oi       <= '0;
            for (int k = 0; k < 8; k++) begin
                r_chain[k] <= sm3_iv(3'(k));
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_len    <= r_len + LW'({i_head.byte_count, 3'b000});
                        r_pstage <= 1'b0;
                        if (sum[6]) begin
                            r_ov_cnt   <= sum[1:0];
                            r_pad_pend <= i_head.last_item;
                            r_state    <= S_LOAD;
                        end else begin
                            r_fill <= sum[5:0];
                            if (i_head.last_item) begin
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_fill   <= 6'(r_ov_cnt);
                    r_ov_cnt <= '0;
                    r_state  <= S_RUN;
                end
                S_RUN: begin
                    if (cstat.done) begin
                        for (int k = 0; k < 8; k++) begin
                            r_chain[k] <= r_chain[k] ^ vars[k];
                        end
                        if (r_final) begin
                            r_final <= 1'b0;
                            r_state <= S_OUT;
                        end else if (r_pad_pend) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= '0;
                    if (len_now) begin
                        r_final    <= 1'b1;
                        r_pad_pend <= 1'b0;
                    end else begin
                        r_pstage   <= 1'b1;
                        r_pad_pend <= 1'b1;
                    end
                    r_state <= S_LOAD;
                end
                S_OUT: begin
                    if (i_pop) begin
                        if (r_oi == 3'd7) begin
                            r_oi    <= '0;
                            r_len   <= '0;
                            r_fill  <= '0;
                            r_state <= S_IDLE;
                            for (int k = 0; k < 8; k++) begin
                                r_chain[k] <= sm3_iv(3'(k));
                            end
                        end else begin
                            r_oi <= r_oi + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/sm3_hash_top.sv
// sm3 hash top level: input queue, packer and compression unit
//
// channel  direction  handshake        word
// input    in         push / full      msg_word, byte_count, last_item
// result   out        empty / pop      digest_word, word_index, last_word
//
// a word that stays inside the current block leaves the packer idle for the next word, unless it is the last
// a full block goes through load, 64 rounds of the shared round unit, and fold
// padding takes one or two more blocks on the last word, then eight digest words
// the input queue keeps taking words until it is full while a block compresses or results wait
// reset is synchronous, active low; no clearing pass is needed
module sm3_hash_top #(
    parameter int LENGTH_COUNTER_WIDTH = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  sm3_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output sm3_pkg::t_out_item o_item
);
    import sm3_pkg::*;

    t_in_item head;
    logic     head_valid, take;

    sm3_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head),
        .i_take  (take)
    );

    sm3_back #(
        .LENGTH_COUNTER_WIDTH (LENGTH_COUNTER_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head),
        .o_take  (take),
        .o_empty (empty),
        .o_item  (o_item),
        .i_pop   (pop)
    );

endmodule

>>> tb/sm3_hash_top_tb.sv
// self-checking testbench for the sm3 hash top level
module sm3_hash_top_tb;
    import sm3_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    t_in_item  i_item = '0;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_item;

    sm3_hash_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_item(o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam logic [31:0] IV_WORDS [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7,
        32'hda8a0600, 32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    // digest of "abc" and of the empty message
    localparam logic [255:0] ABC_DIGEST =
        256'h66c7f0f462eeedd9d1f2d46bdc10e4e24167c4875cf2f7a2297da02b8f4ba8e0;
    localparam logic [255:0] EMPTY_DIGEST =
        256'h1ab21d8355cfa17f8e61194831e81a8f22bec8c728fefb747ed035eb5082aa2b;

    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bits;
    int          block_fill;
    t_out_item   digest_q [$];
    int          fail_cnt = 0;
    int          words_sent = 0;
    bit          feeding_done = 1'b0;

    // two-block padding boundaries
    int          bound_len [5] = '{55, 56, 63, 64, 65};

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [68];
        logic [31:0] v [8];
        logic [31:0] ss1, ss2, tt1, tt2, ff, gg, tj, x;
        for (int k = 0; k < 16; k++) w[k] = msg_block[k];
        for (int k = 16; k < 68; k++) begin
            x = w[k-16] ^ w[k-9] ^ rol(w[k-3], 15);
            w[k] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[k-13], 7) ^ w[k-6];
        end
        for (int k = 0; k < 8; k++) v[k] = hash_state[k];
        for (int j = 0; j < 64; j++) begin
            tj = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
            ss1 = rol(rol(v[0], 12) + v[4] + rol(tj, j), 7);
            ss2 = ss1 ^ rol(v[0], 12);
            if (j < 16) begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end else begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + v[7] + ss1 + w[j];
            v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
            v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
            v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        for (int k = 0; k < 8; k++) hash_state[k] ^= v[k];
    endtask

    task automatic add_msg_byte(input logic [7:0] b);
        if (block_fill % 4 == 0) msg_block[block_fill / 4] = '0;
        msg_block[block_fill / 4][31 - 8 * (block_fill % 4) -: 8] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_msg_block();
            block_fill = 0;
        end
    endtask

    task automatic hash_reset();
        for (int k = 0; k < 8; k++) hash_state[k] = IV_WORDS[k];
        msg_bits = '0;
        block_fill = 0;
    endtask

    task automatic absorb_word(input t_in_item it);
        t_out_item r;
        int n;
        n = (it.byte_count > 4) ? 4 : it.byte_count;
        for (int i = 0; i < n; i++) add_msg_byte(it.msg_word[31 - 8 * i -: 8]);
        msg_bits += 64'(n * 8);
        if (it.last_item) begin
            add_msg_byte(8'h80);
            while (block_fill != 56) add_msg_byte(8'h00);
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            compress_msg_block();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = hash_state[i];
                r.word_index = 3'(i);
                r.last_word = (i == 7);
                digest_q.push_back(r);
            end
            hash_reset();
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_word(input t_in_item it);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_item <= it;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        absorb_word(it);
        words_sent++;
        @(negedge i_clk);
    endtask

    // check the predictor's digest words directly against known values
    task automatic check_known(input logic [255:0] d);
        int base;
        base = digest_q.size() - 8;
        for (int i = 0; i < 8; i++)
            if (digest_q[base + i].digest_word !== d[255 - 32 * i -: 32]) begin
                $display("%0t predictor mismatch word %0d exp %h got %h", $time, i,
                    d[255 - 32 * i -: 32], digest_q[base + i].digest_word);
                fail_cnt++;
            end
    endtask

    typedef struct {
        logic [31:0] w;
        logic [2:0]  n;
        logic        l;
        int          known;
    } t_row;

    // known: 0 none, 1 abc, 2 empty
    t_row stim_rows [] = '{
        '{32'h00000000, 3'd0, 1'b1, 2},
        '{32'h61626300, 3'd3, 1'b1, 1},
        '{32'h61000000, 3'd1, 1'b0, 0},
        '{32'h62630000, 3'd2, 1'b1, 1},
        '{32'hffffffff, 3'd7, 1'b0, 0},
        '{32'hdeadbeef, 3'd0, 1'b0, 0},
        '{32'h00000000, 3'd4, 1'b0, 0},
        '{32'hffffffff, 3'd5, 1'b0, 0},
        '{32'h12345678, 3'd6, 1'b1, 0},
        '{32'hffffffff, 3'd4, 1'b1, 0},
        '{32'h00000000, 3'd4, 1'b1, 0},
        '{32'ha5a5a5a5, 3'd3, 1'b0, 0},
        '{32'h5a5a5a5a, 3'd0, 1'b1, 0}
    };

    task automatic send_msg(input int nbytes);
        t_in_item it;
        int left;
        left = nbytes;
        do begin
            it.msg_word = $urandom;
            if ($urandom_range(0, 5) == 0) it.byte_count = 3'($urandom_range(0, 7));
            else it.byte_count = 3'd4;
            if (it.byte_count > left && left < 4) it.byte_count = 3'(left);
            left -= (it.byte_count > 4) ? 4 : it.byte_count;
            if (left < 0) left = 0;
            it.last_item = (left == 0);
            send_word(it);
        end while (left > 0);
    endtask

    initial begin
        t_in_item it;
        hash_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (stim_rows[r]) begin
            it.msg_word = stim_rows[r].w;
            it.byte_count = stim_rows[r].n;
            it.last_item = stim_rows[r].l;
            send_word(it);
            if (stim_rows[r].known == 1) check_known(ABC_DIGEST);
            if (stim_rows[r].known == 2) check_known(EMPTY_DIGEST);
        end
        foreach (bound_len[k]) send_msg(bound_len[k]);
        while (words_sent < 205) begin
            if ($urandom_range(0, 9) == 0) begin
                it.msg_word = $urandom;
                it.byte_count = 3'($urandom_range(0, 7));
                it.last_item = $urandom_range(0, 1);
                send_word(it);
            end else begin
                send_msg($urandom_range(0, 3) == 0 ? $urandom_range(60, 140)
                                                   : $urandom_range(0, 20));
            end
        end
        push <= 1'b0;
        feeding_done = 1'b1;
    end

    // result side
    initial begin
        t_out_item exp_w;
        int idle;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 9) < 3) begin
                idle = gap_len();
                if (idle > 0) begin
                    pop <= 1'b0;
                    repeat (idle) @(negedge i_clk);
                end
            end
            pop <= 1'b1;
            @(posedge i_clk);
            if (!empty) begin
                if (digest_q.size() == 0) begin
                    $display("%0t unexpected word got %h", $time, o_item);
                    fail_cnt++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (o_item.digest_word !== exp_w.digest_word ||
                        o_item.word_index !== exp_w.word_index ||
                        o_item.last_word !== exp_w.last_word) begin
                        $display("%0t mismatch exp %h/%0d/%b got %h/%0d/%b", $time,
                            exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                            o_item.digest_word, o_item.word_index, o_item.last_word);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        wait (feeding_done);
        wait (digest_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (fail_cnt == 0 && digest_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

>>> filelist.f
src/sm3_pkg.sv
src/sm3_front.sv
src/sm3_comp.sv
src/sm3_back.sv
src/sm3_hash_top.sv
tb/sm3_hash_top_tb.sv
